>>> design/dttf_pkg.sv
// Shared types, constants and helper functions for the decimal text to fixed point unit.
package dttf_pkg;

  localparam int unsigned MagW  = 31;
  localparam int unsigned PadW  = 3;
  localparam int unsigned PowW  = 24;
  localparam int unsigned ProdW = MagW + PowW;

  // One finished number handed from the front to the back.
  typedef struct packed {
    logic [MagW-1:0] mag;
    logic [PadW-1:0] pad;
    logic            neg;
    logic            err;
    logic            ovf;
  } dttf_job_t;

  // Largest magnitude the accumulator may hold for a given accumulator size.
  function automatic logic [MagW-1:0] mag_limit(int unsigned acc_bits);
    logic [63:0] lim;
    lim = (64'd1 << (acc_bits - 1)) - 64'd1;
    if (acc_bits >= 32) begin
      return '1;
    end
    return lim[MagW-1:0];
  endfunction

  // Ten to the power of a padding count.
  function automatic logic [PowW-1:0] pow10(logic [PadW-1:0] n);
    logic [PowW-1:0] p;
    unique case (n)
      3'd0: p = 24'd1;
      3'd1: p = 24'd10;
      3'd2: p = 24'd100;
      3'd3: p = 24'd1000;
      3'd4: p = 24'd10000;
      3'd5: p = 24'd100000;
      3'd6: p = 24'd1000000;
      3'd7: p = 24'd10000000;
    endcase
    return p;
  endfunction

endpackage

>>> design/dttf_front.sv
// Character front end: classify each character and accumulate the magnitude.
module dttf_front import dttf_pkg::*; #(
  parameter int unsigned ACC_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [7:0]      char_code_i,
  input  logic [2:0]      frac_digits_i,
  input  logic            full_i,
  output logic            stall_o,
  output logic            push_o,
  output dttf_job_t       job_o
);

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharAmp   = 8'h26;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] DigitMask = 8'h0F;
  localparam logic [MagW-1:0] Limit = mag_limit(ACC_BITS);

  logic [MagW-1:0] mag_q, mag_d;
  logic            neg_q, neg_d;
  logic            point_q, point_d;
  logic [PadW-1:0] fcnt_q, fcnt_d;
  logic [PadW-1:0] shift_q, shift_d;
  logic            started_q, started_d;
  logic            err_q, err_d;
  logic            ovf_q, ovf_d;

  logic            accept;
  logic            is_term;
  logic            is_digit;
  logic [7:0]      digit;
  logic [MagW+3:0] mac_sum;

  assign stall_o = full_i;
  assign accept  = valid_i & ~full_i;

  assign is_term  = (char_code_i == CharNul) || (char_code_i == CharSpace) ||
                    (char_code_i == CharCr) || (char_code_i == CharLf) ||
                    (char_code_i == CharAmp);
  assign is_digit = (char_code_i >= CharZero) && (char_code_i <= CharNine);
  assign digit    = char_code_i & DigitMask;
  // mag * 10 + digit as (mag << 3) + (mag << 1) + digit
  assign mac_sum  = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0} +
                    {{(MagW - 4){1'b0}}, digit};

  assign push_o    = accept & is_term;
  assign job_o.mag = mag_q;
  assign job_o.pad = shift_q - fcnt_q;
  assign job_o.neg = neg_q;
  assign job_o.err = err_q;
  assign job_o.ovf = ovf_q;

  always_comb begin
    mag_d     = mag_q;
    neg_d     = neg_q;
    point_d   = point_q;
    fcnt_d    = fcnt_q;
    shift_d   = shift_q;
    started_d = started_q;
    err_d     = err_q;
    ovf_d     = ovf_q;
    if (accept) begin
      if (is_term) begin
        // drop all number state once the job is queued
        mag_d     = '0;
        neg_d     = 1'b0;
        point_d   = 1'b0;
        fcnt_d    = '0;
        shift_d   = '0;
        started_d = 1'b0;
        err_d     = 1'b0;
        ovf_d     = 1'b0;
      end else begin
        if (!started_q) begin
          started_d = 1'b1;
          shift_d   = frac_digits_i;
        end
        if (!err_q) begin
          priority if (is_digit) begin
            if (!point_q || (fcnt_q < shift_q)) begin
              if (point_q) begin
                fcnt_d = fcnt_q + 3'd1;
              end
              if (mac_sum > {4'b0000, Limit}) begin
                mag_d = Limit;
                ovf_d = 1'b1;
              end else begin
                mag_d = mac_sum[MagW-1:0];
              end
            end
          end else if ((char_code_i == CharDot) || (char_code_i == CharComma)) begin
            point_d = 1'b1;
            fcnt_d  = '0;
          end else if (char_code_i == CharMinus) begin
            neg_d = 1'b1;
          end else begin
            err_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q     <= '0;
      neg_q     <= 1'b0;
      point_q   <= 1'b0;
      fcnt_q    <= '0;
      shift_q   <= '0;
      started_q <= 1'b0;
      err_q     <= 1'b0;
      ovf_q     <= 1'b0;
    end else begin
      mag_q     <= mag_d;
      neg_q     <= neg_d;
      point_q   <= point_d;
      fcnt_q    <= fcnt_d;
      shift_q   <= shift_d;
      started_q <= started_d;
      err_q     <= err_d;
      ovf_q     <= ovf_d;
    end
  end

endmodule

>>> design/dttf_queue.sv
// Two-entry job queue between the character front end and the scaling back end.
module dttf_queue import dttf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  dttf_job_t job_i,
  input  logic      pop_i,
  output logic      full_o,
  output logic      valid_o,
  output dttf_job_t job_o
);

  dttf_job_t  entry_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = entry_q[rd_q];
  assign pop     = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

endmodule

>>> design/dttf_back.sv
// Scaling back end: pad by a power of ten, clamp, apply the sign and hold the result.
module dttf_back import dttf_pkg::*; #(
  parameter int unsigned ACC_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  dttf_job_t        job_i,
  output logic             pop_o,
  output logic             valid_o,
  input  logic             stall_i,
  output logic signed [31:0] value_o,
  output logic             bad_char_o,
  output logic             saturated_o
);

  localparam logic [MagW-1:0] Limit = mag_limit(ACC_BITS);

  logic             a_valid_q;
  logic [ProdW-1:0] a_prod_q;
  logic             a_neg_q;
  logic             a_err_q;
  logic             a_ovf_q;

  logic             out_valid_q;
  logic [31:0]      value_q;
  logic             bad_q;
  logic             sat_q;

  logic             out_ready;
  logic             a_ready;
  logic             clamp;
  logic [MagW-1:0]  mag_c;
  logic [31:0]      mag_ext;
  logic [31:0]      value_d;
  logic             sat_d;

  assign out_ready = ~out_valid_q | ~stall_i;
  assign a_ready   = ~a_valid_q | out_ready;
  assign pop_o     = q_valid_i & a_ready;

  // Clamping the full product once matches clamping after every step of ten.
  assign clamp   = a_prod_q > {{PowW{1'b0}}, Limit};
  assign mag_c   = clamp ? Limit : a_prod_q[MagW-1:0];
  assign mag_ext = {1'b0, mag_c};

  always_comb begin
    if (a_err_q) begin
      value_d = '0;
      sat_d   = 1'b0;
    end else begin
      value_d = a_neg_q ? (32'd0 - mag_ext) : mag_ext;
      sat_d   = a_ovf_q | clamp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_prod_q <= {{PowW{1'b0}}, job_i.mag} * {{MagW{1'b0}}, pow10(job_i.pad)};
      a_neg_q  <= job_i.neg;
      a_err_q  <= job_i.err;
      a_ovf_q  <= job_i.ovf;
    end
    if (out_ready && a_valid_q) begin
      value_q <= value_d;
      bad_q   <= a_err_q;
      sat_q   <= sat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= q_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= a_valid_q;
      end
    end
  end

  assign valid_o     = out_valid_q;
  assign value_o     = value_q;
  assign bad_char_o  = bad_q;
  assign saturated_o = sat_q;

endmodule

>>> design/decimal_text_to_fixed_point_unit.sv
// Top level of the ASCII decimal text to scaled fixed-point converter.
//
// Feed one ASCII character per beat on the input channel; frac_digits_i is
// sampled with the first character of each number. Digits build the
// magnitude, '-' anywhere makes the number negative, '.' or ',' starts (or
// restarts) the fraction, and fractional digits past the requested count are
// dropped. A NUL, space, CR, LF or '&' ends the number and yields exactly one
// result beat: the number times ten to frac_digits, two's complement, clamped
// to min(2^(ACC_BITS-1)-1, 2^31-1) with saturated_o set when clamping took
// place. Any other character gives value 0 with bad_char_o set. Characters
// that are not terminators yield no result beat. The unit takes one
// character every cycle while stall_o is low: the front end does a
// multiply-by-ten accumulate per character (shift and add), and a two-entry
// queue hands finished numbers to the back end, which scales them with one
// 31x24 multiply stage and one clamp-and-sign stage into the output register.
// stall_o rises only when both queue entries are taken, which happens only
// while the output side is stalled.
module decimal_text_to_fixed_point_unit import dttf_pkg::*; #(
  parameter int unsigned ACC_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [7:0]         char_code_i,
  input  logic [2:0]         frac_digits_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [31:0] value_o,
  output logic               bad_char_o,
  output logic               saturated_o
);

  // jobs move front -> queue -> back
  dttf_job_t front_job;
  dttf_job_t queue_job;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_valid;

  // Classify characters and accumulate; push one job per terminator.
  dttf_front #(
    .ACC_BITS(ACC_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .char_code_i  (char_code_i),
    .frac_digits_i(frac_digits_i),
    .full_i       (q_full),
    .stall_o      (stall_o),
    .push_o       (push),
    .job_o        (front_job)
  );

  // Hold finished numbers so either side can stall on its own.
  dttf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (front_job),
    .pop_i  (pop),
    .full_o (q_full),
    .valid_o(q_valid),
    .job_o  (queue_job)
  );

  // Pad, clamp, sign and register the result beat.
  dttf_back #(
    .ACC_BITS(ACC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .job_i      (queue_job),
    .pop_o      (pop),
    .valid_o    (valid_o),
    .stall_i    (stall_i),
    .value_o    (value_o),
    .bad_char_o (bad_char_o),
    .saturated_o(saturated_o)
  );

endmodule

>>> test/tb_decimal_text_to_fixed_point_unit.sv
// Self-checking testbench for the decimal text to fixed point unit.
`timescale 1ns / 1ps

module tb_decimal_text_to_fixed_point_unit;

  localparam int unsigned ACC_BITS = 32;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned ITEM_COUNT = 850;
  localparam int unsigned DIRECTED_ROWS = 25;

  // Largest magnitude that the number may reach before it saturates.
  localparam logic [63:0] MAG_CAP = (ACC_BITS - 1 < 31) ?
                                    ((64'd1 << (ACC_BITS - 1)) - 64'd1) : 64'd2147483647;

  // Character codes that steer the parser.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_BAD   = 8'hFF;

  // One finished number as it leaves the unit.
  typedef struct packed {
    logic signed [31:0] value;
    logic               bad_char;
    logic               saturated;
  } number_t;

  // One directed beat; typed rows carry their expected number inline.
  typedef struct packed {
    logic [7:0]  ch;
    logic [2:0]  fd;
    logic        typed;
    logic [31:0] value;
    logic        bad_char;
    logic        saturated;
  } text_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              valid_i = 1'b0;
  logic              stall_o;
  logic [7:0]        char_code_i = 8'h00;
  logic [2:0]        frac_digits_i = 3'd0;
  logic              valid_o;
  logic              stall_i = 1'b0;
  logic signed [31:0] value_o;
  logic              bad_char_o;
  logic              saturated_o;

  decimal_text_to_fixed_point_unit #(
    .ACC_BITS(ACC_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .char_code_i  (char_code_i),
    .frac_digits_i(frac_digits_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .value_o      (value_o),
    .bad_char_o   (bad_char_o),
    .saturated_o  (saturated_o)
  );

  // Directed text: empty number, shift of seven with a sign, saturation by
  // padding, an invalid character followed by ignored ones, excess fraction
  // digits with a repeated point, and negative zero. Every terminator shows up.
  text_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    '{CH_NUL,         3'd0, 1'b1, 32'd0,          1'b0, 1'b0},
    '{CH_MINUS,       3'd7, 1'b0, 32'd0,          1'b0, 1'b0},
    '{CH_ZERO + 8'd1, 3'd7, 1'b0, 32'd0,          1'b0, 1'b0},
    '{CH_DOT,         3'd7, 1'b0, 32'd0,          1'b0, 1'b0},
    '{CH_ZERO + 8'd5, 3'd7, 1'b0, 32'd0,          1'b0, 1'b0},
    '{CH_CR,          3'd7, 1'b1, -32'sd15000000, 1'b0, 1'b0},
    '{CH_NINE,        3'd7, 1'b0, 32'd0,          1'b0, 1'b0},
    '{CH_NINE,        3'd0, 1'b0, 32'd0,          1'b0, 1'b0},
    '{CH_NINE,        3'd0, 1'b0, 32'd0,          1'b0, 1'b0},
    '{CH_SPACE,       3'd0, 1'b1, 32'd2147483647, 1'b0, 1'b1},
    '{CH_BAD,         3'd0, 1'b0, 32'd0,          1'b0, 1'b0},
    '{CH_ZERO + 8'd5, 3'd7, 1'b0, 32'd0,          1'b0, 1'b0},
    '{CH_MINUS,       3'd7, 1'b0, 32'd0,          1'b0, 1'b0},
    '{CH_LF,          3'd7, 1'b1, 32'd0,          1'b1, 1'b0},
    '{CH_ZERO + 8'd3, 3'd2, 1'b0, 32'd0,          1'b0, 1'b0},
    '{CH_COMMA,       3'd2, 1'b0, 32'd0,          1'b0, 1'b0},
    '{CH_ZERO + 8'd1, 3'd2, 1'b0, 32'd0,          1'b0, 1'b0},
    '{CH_ZERO + 8'd2, 3'd2, 1'b0, 32'd0,          1'b0, 1'b0},
    '{CH_ZERO + 8'd3, 3'd2, 1'b0, 32'd0,          1'b0, 1'b0},
    '{CH_DOT,         3'd2, 1'b0, 32'd0,          1'b0, 1'b0},
    '{CH_ZERO + 8'd4, 3'd2, 1'b0, 32'd0,          1'b0, 1'b0},
    '{CH_SPACE,       3'd2, 1'b0, 32'd0,          1'b0, 1'b0},
    '{CH_MINUS,       3'd3, 1'b0, 32'd0,          1'b0, 1'b0},
    '{CH_ZERO,        3'd3, 1'b0, 32'd0,          1'b0, 1'b0},
    '{CH_AMP,         3'd3, 1'b1, 32'd0,          1'b0, 1'b0}
  };

  // Parser state mirrored from the unit.
  logic [63:0] num_mag;
  logic        num_neg;
  logic        num_point;
  logic [2:0]  num_frac_cnt;
  logic [2:0]  num_shift;
  logic        num_started;
  logic        num_bad;
  logic        num_ovf;

  number_t     expected_numbers[$];
  int unsigned items_sent = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 16;
  int unsigned recv_stall_pct = 60;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit is_end_char(input logic [7:0] ch);
    return ch == CH_NUL || ch == CH_SPACE || ch == CH_CR || ch == CH_LF || ch == CH_AMP;
  endfunction

  function automatic bit is_digit_char(input logic [7:0] ch);
    return ch >= CH_ZERO && ch <= CH_NINE;
  endfunction

  // Multiply by ten and add; clamp at the cap and remember the clamp.
  function automatic logic [63:0] times_ten_plus(input logic [63:0] mag, input logic [3:0] d);
    logic [63:0] sum;
    sum = mag * 64'd10 + {60'd0, d};
    if (sum > MAG_CAP) begin
      num_ovf = 1'b1;
      return MAG_CAP;
    end
    return sum;
  endfunction

  task automatic clear_number();
    num_mag = '0;
    num_neg = 1'b0;
    num_point = 1'b0;
    num_frac_cnt = '0;
    num_shift = '0;
    num_started = 1'b0;
    num_bad = 1'b0;
    num_ovf = 1'b0;
  endtask

  // Advance the parser by one character; a terminator yields a number.
  task automatic parse_char(input logic [7:0] ch, input logic [2:0] fd,
                            output bit done, output number_t num);
    logic [63:0] mag;
    int          i;
    done = 1'b0;
    num = '0;
    if (is_end_char(ch)) begin
      done = 1'b1;
      if (num_bad) begin
        num.bad_char = 1'b1;
      end else begin
        mag = num_mag;
        for (i = int'(num_frac_cnt); i < int'(num_shift); i++) begin
          mag = times_ten_plus(mag, 4'd0);
        end
        num.value = num_neg ? -mag[31:0] : mag[31:0];
        num.saturated = num_ovf;
      end
      clear_number();
      return;
    end
    if (!num_started) begin
      num_started = 1'b1;
      num_shift = fd;
    end
    if (num_bad) return;
    if (is_digit_char(ch)) begin
      if (num_point) begin
        // Drop fraction digits past the requested count.
        if (num_frac_cnt >= num_shift) return;
        num_frac_cnt = num_frac_cnt + 3'd1;
      end
      num_mag = times_ten_plus(num_mag, ch[3:0]);
    end else if (ch == CH_DOT || ch == CH_COMMA) begin
      num_point = 1'b1;
      num_frac_cnt = '0;
    end else if (ch == CH_MINUS) begin
      num_neg = 1'b1;
    end else begin
      num_bad = 1'b1;
    end
  endtask

  // Drive one character beat, hold it until accepted, then predict.
  task automatic drive_char(input logic [7:0] ch, input logic [2:0] fd,
                            input bit typed, input number_t typed_num);
    bit      done;
    number_t num;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i <= 1'b1;
    char_code_i <= ch;
    frac_digits_i <= fd;
    do @(posedge clk_i); while (stall_o);
    parse_char(ch, fd, done, num);
    if (done) expected_numbers.push_back(typed ? typed_num : num);
    items_sent++;
  endtask

  // Build one number text: mostly well-formed with random content, some noise
  // bytes, stray points, invalid characters and long digit runs that saturate.
  task automatic send_number();
    logic [7:0] text[$];
    logic [7:0] ch;
    logic [2:0] fd;
    int         n;
    int         k;
    fd = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 99) < 8) begin
      text.push_back(8'($urandom_range(0, 255)));
    end else begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 13) : $urandom_range(0, 6);
      for (k = 0; k < n; k++) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 1)) begin
        text.push_back($urandom_range(0, 1) ? CH_DOT : CH_COMMA);
        n = $urandom_range(0, 9);
        for (k = 0; k < n; k++) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 9) == 0) begin
        text.push_back($urandom_range(0, 1) ? CH_DOT : CH_COMMA);
        text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 2) == 0) text.insert($urandom_range(0, text.size()), CH_MINUS);
      if ($urandom_range(0, 9) == 0) begin
        do ch = 8'($urandom_range(0, 255));
        while (is_end_char(ch) || is_digit_char(ch) || ch == CH_DOT || ch == CH_COMMA ||
               ch == CH_MINUS);
        text.insert($urandom_range(0, text.size()), ch);
      end
      case ($urandom_range(0, 4))
        0: text.push_back(CH_NUL);
        1: text.push_back(CH_SPACE);
        2: text.push_back(CH_CR);
        3: text.push_back(CH_LF);
        default: text.push_back(CH_AMP);
      endcase
    end
    // Only the first character's shift counts; vary the rest anyway.
    for (k = 0; k < text.size(); k++) begin
      drive_char(text[k], (k == 0) ? fd : 3'($urandom_range(0, 7)), 1'b0, '0);
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Receiver: stall at random at the falling edge.
  always @(negedge clk_i) begin
    stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Check each result beat against the oldest expected number.
  always @(posedge clk_i) begin
    number_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_numbers.size() == 0) begin
        report_mismatch("unexpected result beat, value", value_o, 0);
      end else begin
        want = expected_numbers.pop_front();
        if (value_o !== want.value) report_mismatch("value", value_o, want.value);
        if (bad_char_o !== want.bad_char) report_mismatch("bad_char", bad_char_o, want.bad_char);
        if (saturated_o !== want.saturated) begin
          report_mismatch("saturated", saturated_o, want.saturated);
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int      r;
    number_t typed_num;
    clear_number();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (r = 0; r < DIRECTED_ROWS; r++) begin
      typed_num.value = directed_rows[r].value;
      typed_num.bad_char = directed_rows[r].bad_char;
      typed_num.saturated = directed_rows[r].saturated;
      drive_char(directed_rows[r].ch, directed_rows[r].fd, directed_rows[r].typed, typed_num);
    end

    // Swap the idling sides a third of the way in, then stop idling.
    while (items_sent < ITEM_COUNT) begin
      if (items_sent >= 2 * ITEM_COUNT / 3) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else if (items_sent >= ITEM_COUNT / 3) begin
        send_idle_pct = 60;
        recv_stall_pct = 16;
      end
      send_number();
    end
    @(negedge clk_i);
    valid_i <= 1'b0;

    while (expected_numbers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
